// File: sv/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Types, character codes and range tables shared by the integer literal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

  localparam logic [1:0] RADIX_NONE = 2'd0;
  localparam logic [1:0] RADIX_DEC  = 2'd1;
  localparam logic [1:0] RADIX_HEX  = 2'd2;
  localparam logic [1:0] RADIX_BIN  = 2'd3;

  localparam logic [1:0] POS_EMPTY  = 2'd0;
  localparam logic [1:0] POS_ZERO   = 2'd1;
  localparam logic [1:0] POS_PREFIX = 2'd2;
  localparam logic [1:0] POS_DIGITS = 2'd3;

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_B    = 8'h42;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_B    = 8'h62;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_LO_X    = 8'h78;

  localparam logic [2:0] KIND_RESET = 3'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [63:0] parsed_value;
    logic        parse_ok;
  } out_item_t;

  typedef struct packed {
    logic [63:0] magnitude;
    logic        overflow;
    logic        negative;
    logic [1:0]  radix;
    logic [1:0]  position;
    logic        error;
  } token_t;

  typedef struct packed {
    token_t     tok;
    logic [2:0] kind;
  } fin_t;

  function automatic logic [63:0] width_mask(input logic [1:0] size);
    logic [63:0] m;
    unique case (size)
      2'd0: m = 64'h0000_0000_0000_00FF;
      2'd1: m = 64'h0000_0000_0000_FFFF;
      2'd2: m = 64'h0000_0000_FFFF_FFFF;
      2'd3: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] neg_limit(input logic [1:0] size);
    logic [63:0] m;
    unique case (size)
      2'd0: m = 64'h0000_0000_0000_0080;
      2'd1: m = 64'h0000_0000_0000_8000;
      2'd2: m = 64'h0000_0000_8000_0000;
      2'd3: m = 64'h8000_0000_0000_0000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: sv/integer_literal_parser.sv
// ----------------------------------------------------------------------------
// integer_literal_parser
// Parses decimal, 0x hex and 0b binary integer tokens, one character a request.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in      | in        | in_item_t  {char_code, last_char}
//  out     | out       | out_item_t {parsed_value, parse_ok}
//  cfg     | in        | cfg_data   target_kind
//
//  One character request is taken every cycle while no stall on out holds the stages.
//  The last character passes the input, token and result registers before its result is valid.
//  A stall on out holds the result register and then the stages behind it.
//  Reset empties all stages, clears the token and sets target_kind to 3.
//  Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_literal_parser
  import ilp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  logic [2:0] target_kind;
  logic       fin_valid;
  logic       fin_ready;
  fin_t       fin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_kind <= KIND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      target_kind <= cfg_data;
    end
  end

  ilp_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .target_kind (target_kind),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .fin_valid   (fin_valid),
    .fin_ready   (fin_ready),
    .fin         (fin)
  );

  ilp_check u_check (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.parse_ok |-> out_item.parsed_value == 64'd0)
    else $error("failed token carries a nonzero value");

  a_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.parse_ok
      |-> (out_item.parsed_value & ~width_mask(target_kind[1:0])) == 64'd0)
    else $error("value exceeds target width");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: sv/ilp_scan.sv
// ----------------------------------------------------------------------------
// ilp_scan
// Input register and per-character token scan; hands finished tokens onward.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_scan
  import ilp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [2:0] target_kind,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       fin_valid,
  input  logic       fin_ready,
  output fin_t       fin
);

  logic     a_valid;
  in_item_t a_item;
  token_t   tok;
  token_t   tok_next;
  logic     b_ready;
  logic     a_go;

  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  dval;
  logic [67:0] wide;

  assign b_ready  = !fin_valid || fin_ready;
  assign in_ready = !a_valid || b_ready;
  assign a_go     = a_valid && b_ready;
  assign c        = a_item.char_code;

  always_comb begin
    is_digit = 1'b0;
    dval     = c[3:0];
    unique case (tok.radix)
      RADIX_BIN: begin
        is_digit = (c == CH_ZERO) || (c == CH_ONE);
      end
      RADIX_HEX: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          is_digit = 1'b1;
        end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
          is_digit = 1'b1;
          dval     = c[3:0] + 4'd9;
        end
      end
      RADIX_DEC, RADIX_NONE: begin
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
      end
    endcase
  end

  always_comb begin
    unique case (tok.radix)
      RADIX_DEC:  wide = {1'b0, tok.magnitude, 3'b000} + {3'b000, tok.magnitude, 1'b0}
                         + {64'd0, dval};
      RADIX_HEX:  wide = {tok.magnitude, 4'b0000} + {64'd0, dval};
      RADIX_BIN:  wide = {3'b000, tok.magnitude, 1'b0} + {64'd0, dval};
      RADIX_NONE: wide = {64'd0, dval};
    endcase
  end

  always_comb begin
    tok_next = tok;
    if (!tok.error) begin
      if (tok.position == POS_EMPTY && tok.radix == RADIX_NONE && !tok.negative
          && c == CH_MINUS) begin
        if (target_kind[2]) begin
          tok_next.negative = 1'b1;
        end else begin
          tok_next.error = 1'b1;
        end
      end else if (tok.radix == RADIX_NONE) begin
        if (tok.position == POS_ZERO && (c == CH_LO_X || c == CH_UP_X)) begin
          tok_next.radix    = RADIX_HEX;
          tok_next.position = POS_PREFIX;
        end else if (tok.position == POS_ZERO && (c == CH_LO_B || c == CH_UP_B)) begin
          tok_next.radix    = RADIX_BIN;
          tok_next.position = POS_PREFIX;
        end else if (!is_digit) begin
          tok_next.error = 1'b1;
        end else if (tok.position == POS_EMPTY && dval == 4'd0) begin
          tok_next.position = POS_ZERO;
        end else begin
          tok_next.radix     = RADIX_DEC;
          tok_next.position  = POS_DIGITS;
          tok_next.magnitude = {60'd0, dval};
        end
      end else if (!is_digit) begin
        tok_next.error = 1'b1;
      end else begin
        tok_next.position = POS_DIGITS;
        if (!tok.overflow) begin
          if (wide[67:64] != 4'd0) begin
            tok_next.overflow = 1'b1;
          end else begin
            tok_next.magnitude = wide[63:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else if (a_go) begin
      tok <= a_item.last_char ? '0 : tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (b_ready) begin
      fin_valid <= a_valid && a_item.last_char;
    end
    if (a_go && a_item.last_char) begin
      fin <= '{tok: tok_next, kind: target_kind};
    end
  end

endmodule

`default_nettype wire

// File: sv/ilp_check.sv
// ----------------------------------------------------------------------------
// ilp_check
// Range check of a finished token against its target and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_check
  import ilp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fin_valid,
  output logic      fin_ready,
  input  fin_t      fin,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [63:0] mask;
  logic [63:0] lim;
  logic [63:0] mag;
  logic        base_ok;
  logic        ok;
  logic [63:0] value;
  out_item_t   out_item_next;

  assign fin_ready = !out_valid || out_ready;
  assign mask      = width_mask(fin.kind[1:0]);
  assign lim       = neg_limit(fin.kind[1:0]);
  assign mag       = fin.tok.magnitude;

  always_comb begin
    base_ok = !fin.tok.error && !fin.tok.overflow && fin.tok.position != POS_EMPTY
              && !((fin.tok.radix == RADIX_HEX || fin.tok.radix == RADIX_BIN)
                   && fin.tok.position == POS_PREFIX);
    priority if (!fin.kind[2]) begin
      ok    = !fin.tok.negative && ((mag & ~mask) == 64'd0);
      value = mag;
    end else if (fin.tok.negative) begin
      ok    = mag <= lim;
      value = 64'd0 - mag;
    end else begin
      ok    = mag < lim;
      value = mag;
    end
    out_item_next.parse_ok     = base_ok && ok;
    out_item_next.parsed_value = (base_ok && ok) ? (value & mask) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_ready) begin
      out_valid <= fin_valid;
    end
    if (fin_valid && fin_ready) begin
      out_item <= out_item_next;
    end
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// integer_literal_parser testbench
// Streams decimal, hex and binary integer tokens one character per request,
// with random gaps on the input and random stalls on the result channel, and
// changes the target kind between tokens and inside tokens. A behavioral
// parser tracks the token state and queues the value and ok flag that each
// last character should produce; a monitor compares every result with the
// oldest queued one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ilp_pkg::*;

  typedef logic [7:0] char_q_t [$];

  localparam logic [2:0] KIND_U8  = 3'd0;
  localparam logic [2:0] KIND_U16 = 3'd1;
  localparam logic [2:0] KIND_U32 = 3'd2;
  localparam logic [2:0] KIND_U64 = 3'd3;
  localparam logic [2:0] KIND_S8  = 3'd4;
  localparam logic [2:0] KIND_S16 = 3'd5;
  localparam logic [2:0] KIND_S32 = 3'd6;
  localparam logic [2:0] KIND_S64 = 3'd7;

  localparam logic [2:0] KIND_ORDER [8] = '{KIND_U8, KIND_S64, KIND_U16, KIND_S8,
                                            KIND_U32, KIND_S16, KIND_U64, KIND_S32};

  localparam int IDLE_PCT      = 14;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_CHARS   = 72;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data = '0;

  logic [7:0] token_marks [12] = '{CH_MINUS, CH_ZERO, CH_ONE, CH_NINE, CH_UP_A, CH_UP_B,
                                   CH_UP_F, CH_UP_X, CH_LO_A, CH_LO_B, CH_LO_F, CH_LO_X};

  // parser state mirrored from the token seen so far
  logic [2:0]  cur_kind = KIND_RESET;
  logic [63:0] tok_mag = '0;
  logic        tok_ovf = 1'b0;
  logic        tok_neg = 1'b0;
  logic [1:0]  tok_radix = RADIX_NONE;
  logic [1:0]  tok_pos = POS_EMPTY;
  logic        tok_err = 1'b0;

  out_item_t pending_parses [$];
  out_item_t want;

  int idle_pct = IDLE_PCT;
  int error_count = 0;
  int cycle_count = 0;
  int chars_sent = 0;
  int tokens_sent = 0;
  int results_checked = 0;
  int ok_results = 0;
  int kind_writes = 0;
  int mid_changes = 0;

  integer_literal_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    return (sz == 2'd3) ? '1 : ((64'd1 << (8 << sz)) - 64'd1);
  endfunction

  function automatic logic [63:0] neg_bound(input logic [1:0] sz);
    return 64'd1 << ((8 << sz) - 1);
  endfunction

  function automatic int digit_value(input logic [7:0] c, input logic [1:0] radix);
    if (radix == RADIX_BIN) return (c == CH_ZERO || c == CH_ONE) ? int'(c - CH_ZERO) : -1;
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (radix == RADIX_HEX) begin
      if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    end
    return -1;
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'(CH_ZERO + d);
    return 8'(($urandom_range(1) ? CH_LO_A : CH_UP_A) + d - 10);
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic last);
    int          d;
    logic [63:0] base;
    logic [67:0] wide;
    logic [63:0] mask;
    logic [63:0] bound;
    logic [63:0] val;
    logic        ok;
    if (!tok_err) begin
      if (tok_pos == POS_EMPTY && tok_radix == RADIX_NONE && !tok_neg && c == CH_MINUS) begin
        if (cur_kind >= KIND_S8) tok_neg = 1'b1;
        else tok_err = 1'b1;
      end else if (tok_radix == RADIX_NONE) begin
        if (tok_pos == POS_ZERO && (c == CH_LO_X || c == CH_UP_X)) begin
          tok_radix = RADIX_HEX;
          tok_pos = POS_PREFIX;
        end else if (tok_pos == POS_ZERO && (c == CH_LO_B || c == CH_UP_B)) begin
          tok_radix = RADIX_BIN;
          tok_pos = POS_PREFIX;
        end else if (c < CH_ZERO || c > CH_NINE) begin
          tok_err = 1'b1;
        end else if (tok_pos == POS_EMPTY && c == CH_ZERO) begin
          tok_pos = POS_ZERO;
        end else begin
          tok_radix = RADIX_DEC;
          tok_pos = POS_DIGITS;
          tok_mag = 64'(c - CH_ZERO);
        end
      end else begin
        d = digit_value(c, tok_radix);
        if (d < 0) begin
          tok_err = 1'b1;
        end else begin
          base = (tok_radix == RADIX_HEX) ? 64'd16 : (tok_radix == RADIX_BIN) ? 64'd2 : 64'd10;
          if (!tok_ovf) begin
            wide = {4'b0, tok_mag} * base + 68'(d);
            if (wide[67:64] != 4'b0) tok_ovf = 1'b1;
            else tok_mag = wide[63:0];
          end
          tok_pos = POS_DIGITS;
        end
      end
    end
    if (last) begin
      mask = size_mask(cur_kind[1:0]);
      bound = neg_bound(cur_kind[1:0]);
      val = '0;
      ok = !tok_err && !tok_ovf && tok_pos != POS_EMPTY &&
           !((tok_radix == RADIX_HEX || tok_radix == RADIX_BIN) && tok_pos == POS_PREFIX);
      if (ok) begin
        if (cur_kind < KIND_S8) begin
          ok = !tok_neg && tok_mag <= mask;
          val = tok_mag;
        end else if (tok_neg) begin
          ok = tok_mag <= bound;
          val = (64'd0 - tok_mag) & mask;
        end else begin
          ok = tok_mag <= bound - 64'd1;
          val = tok_mag;
        end
      end
      pending_parses.push_back('{parsed_value: ok ? (val & mask) : 64'd0, parse_ok: ok});
      tok_mag = '0;
      tok_ovf = 1'b0;
      tok_neg = 1'b0;
      tok_radix = RADIX_NONE;
      tok_pos = POS_EMPTY;
      tok_err = 1'b0;
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= '{char_code: c, last_char: last};
    do @(posedge clk); while (!in_ready);
    parse_char(c, last);
    chars_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_parses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target_kind(input logic [2:0] kind);
    cfg_valid <= 1'b1;
    cfg_data <= kind;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_kind = kind;
    kind_writes++;
  endtask

  task automatic send_token(input char_q_t chars, input int split_at, input logic [2:0] kind);
    for (int i = 0; i < chars.size(); i++) begin
      if (i == split_at) begin
        hold_until_drained();
        write_target_kind(kind);
        mid_changes++;
      end
      send_char(chars[i], i == chars.size() - 1);
    end
    tokens_sent++;
  endtask

  function automatic char_q_t text(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic char_q_t make_literal(input logic [2:0] kind);
    char_q_t     q;
    logic [63:0] v;
    logic [63:0] mask;
    logic [63:0] bound;
    logic [63:0] base;
    logic [1:0]  radix;
    int          extra;
    mask = size_mask(kind[1:0]);
    bound = neg_bound(kind[1:0]);
    case ($urandom_range(9))
      0, 1, 2: v = 64'($urandom_range(0, 300));
      3:       v = mask;
      4:       v = mask + 64'd1;
      5:       v = bound;
      6:       v = bound - 64'd1;
      7:       v = bound + 64'd1;
      8:       v = {$urandom, $urandom} & mask;
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    case ($urandom_range(9))
      6, 7, 8: radix = RADIX_HEX;
      9:       radix = RADIX_BIN;
      default: radix = RADIX_DEC;
    endcase
    if (radix == RADIX_BIN && v >= 64'd4096) radix = RADIX_HEX;
    base = (radix == RADIX_HEX) ? 64'd16 : (radix == RADIX_BIN) ? 64'd2 : 64'd10;
    extra = ($urandom_range(24) == 0) ? $urandom_range(1, 3) : 0;
    do begin
      q.push_front(digit_char(int'(v % base)));
      v = v / base;
    end while (v != 0);
    repeat (extra) q.push_back(digit_char($urandom_range(0, int'(base) - 1)));
    if (radix == RADIX_DEC && $urandom_range(9) == 0) q.push_front(CH_ZERO);
    if (radix == RADIX_HEX) begin
      q.push_front($urandom_range(1) ? CH_LO_X : CH_UP_X);
      q.push_front(CH_ZERO);
    end else if (radix == RADIX_BIN) begin
      q.push_front($urandom_range(1) ? CH_LO_B : CH_UP_B);
      q.push_front(CH_ZERO);
    end
    if ((kind >= KIND_S8) ? ($urandom_range(9) < 4) : ($urandom_range(19) == 0))
      q.push_front(CH_MINUS);
    if ($urandom_range(19) == 0) q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
    return q;
  endfunction

  function automatic char_q_t make_noise();
    char_q_t q;
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(1)) q.push_back(8'($urandom));
      else q.push_back(token_marks[$urandom_range(0, 11)]);
    end
    return q;
  endfunction

  task automatic test_unsigned_forms();
    char_q_t q;
    q = '{CH_NINE, 8'hFF, 8'h00};
    send_token(text("0"), -1, KIND_RESET);
    send_token(text("0x"), -1, KIND_RESET);
    send_token(text("-5"), -1, KIND_RESET);
    send_token(text("0B1"), -1, KIND_RESET);
    send_token(text("0XfF"), -1, KIND_RESET);
    send_token(q, -1, KIND_RESET);
  endtask

  task automatic test_signed_forms();
    hold_until_drained();
    write_target_kind(KIND_S64);
    send_token(text("-"), -1, KIND_S64);
    send_token(text("-0"), -1, KIND_S64);
    send_token(text("-9"), -1, KIND_S64);
  endtask

  task automatic test_kind_change_mid_token();
    hold_until_drained();
    write_target_kind(KIND_S8);
    send_token(text("-1"), 1, KIND_U8);
  endtask

  task automatic test_random_tokens();
    char_q_t    tok;
    int         phase_start;
    int         split;
    logic [2:0] kind;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = (p < 8) ? KIND_ORDER[p] : 3'($urandom_range(0, 7));
      idle_pct = (p == 4) ? 0 : IDLE_PCT;
      hold_until_drained();
      write_target_kind(kind);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        if ($urandom_range(99) < 75) tok = make_literal(cur_kind);
        else tok = make_noise();
        split = -1;
        if (tok.size() > 1 && $urandom_range(99) < 6) split = $urandom_range(1, tok.size() - 1);
        send_token(tok, split, 3'($urandom_range(0, 7)));
      end
    end
    idle_pct = IDLE_PCT;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_parses.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %h ok %b",
                 $time, out_item.parsed_value, out_item.parse_ok);
        error_count++;
      end else begin
        want = pending_parses.pop_front();
        if (out_item.parsed_value !== want.parsed_value) begin
          $display("%0t: parsed_value mismatch: expected %h actual %h",
                   $time, want.parsed_value, out_item.parsed_value);
          error_count++;
        end
        if (out_item.parse_ok !== want.parse_ok) begin
          $display("%0t: parse_ok mismatch: expected %b actual %b",
                   $time, want.parse_ok, out_item.parse_ok);
          error_count++;
        end
        results_checked++;
        if (want.parse_ok) ok_results++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, pending_parses.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_unsigned_forms();
    test_signed_forms();
    test_kind_change_mid_token();
    test_random_tokens();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d characters in %0d tokens; %0d target kind writes, %0d inside a token.",
             chars_sent, tokens_sent, kind_writes, mid_changes);
    $display("Checked %0d results, %0d accepted and %0d rejected; %0d mismatches.",
             results_checked, ok_results, results_checked - ok_results, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
sv/ilp_pkg.sv
sv/ilp_scan.sv
sv/ilp_check.sv
sv/integer_literal_parser.sv
sim/testbench.sv
